FILE: rtl/pfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfr_pkg
// Shared types and constants of the packet fragment reassembler.
// ----------------------------------------------------------------------------
package pfr_pkg;

	localparam int FRAME_BUFFER_BYTES = 65535;
	localparam int HEADER_BYTES       = 18;

	// header byte positions
	localparam logic [15:0] POS_TYPE      = 16'd0;
	localparam logic [15:0] POS_SEQ_FIRST = 16'd1;
	localparam logic [15:0] POS_SEQ_LAST  = 16'd4;
	localparam logic [15:0] POS_FLAGS     = 16'd13;
	localparam logic [15:0] POS_LEN_FIRST = 16'd14;
	localparam logic [15:0] POS_LEN_LAST  = 16'(HEADER_BYTES - 1);

	localparam logic [15:0] HDR_BYTES16 = 16'(HEADER_BYTES);
	localparam logic [32:0] HDR_BYTES33 = 33'(HEADER_BYTES);
	localparam logic [32:0] FRAME_CAP33 = 33'(FRAME_BUFFER_BYTES);
	localparam logic [15:0] IDX_MAX     = 16'hFFFF;

	// flag bit positions
	localparam int FLAG_FRAG_BIT = 1;
	localparam int FLAG_LAST_BIT = 2;

	localparam logic [7:0] ACCEPTED_TYPE_RST = 8'd1;

	typedef enum logic [2:0] {
		ST_SINGLE     = 3'd0,
		ST_APPENDED   = 3'd1,
		ST_COMPLETE   = 3'd2,
		ST_SHORT      = 3'd3,
		ST_INCOMPLETE = 3'd4,
		ST_WRONG_TYPE = 3'd5,
		ST_SEQ_MISM   = 3'd6,
		ST_OVERFLOW   = 3'd7
	} status_t;

	typedef struct packed {
		logic [15:0] byte_index;
		logic [7:0]  header_type;
		logic [31:0] header_sequence;
		logic [7:0]  header_flags;
		logic [31:0] header_length;
		logic        reassembling;
		logic [31:0] expected_seq;
		logic [15:0] committed_length;
	} pfr_state_t;

	typedef struct packed {
		logic [7:0]  payload_byte;
		logic        payload_valid;
		logic        payload_target;
		logic [15:0] write_offset;
		logic        packet_done;
		status_t     status;
		logic        frame_ready;
		logic [15:0] frame_length;
		logic        dropped_partial;
	} pfr_result_t;

endpackage

FILE: rtl/pfr_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfr_step
// Per-byte logic: header capture, payload placement and end-of-packet verdict.
// ----------------------------------------------------------------------------
module pfr_step import pfr_pkg::*; (
	input  pfr_state_t  st,
	input  logic [7:0]  accepted_type,
	input  logic [7:0]  data_byte,
	input  logic        packet_end,
	output pfr_state_t  nst,
	output pfr_result_t res
);

	logic [15:0] idx;
	logic [7:0]  h_type;
	logic [31:0] h_seq;
	logic [7:0]  h_flags;
	logic [31:0] h_len;
	logic        frag;
	logic        frag_cont;
	logic [15:0] base;
	logic        seq_ok;
	logic        fits;
	logic        type_ok;
	logic [32:0] sum_len;
	logic [15:0] pos;
	logic [15:0] total;

	always_comb begin
		idx     = st.byte_index;
		h_type  = st.header_type;
		h_seq   = st.header_sequence;
		h_flags = st.header_flags;
		h_len   = st.header_length;

		// header capture happens before this byte's decisions
		if (idx == POS_TYPE) begin
			h_type = data_byte;
		end else if (idx inside {[POS_SEQ_FIRST:POS_SEQ_LAST]}) begin
			h_seq = {st.header_sequence[23:0], data_byte};
		end else if (idx == POS_FLAGS) begin
			h_flags = data_byte;
		end else if (idx inside {[POS_LEN_FIRST:POS_LEN_LAST]}) begin
			h_len = {st.header_length[23:0], data_byte};
		end

		frag      = h_flags[FLAG_FRAG_BIT];
		frag_cont = frag && st.reassembling;
		base      = frag_cont ? st.committed_length : 16'd0;
		seq_ok    = !frag_cont || (h_seq == st.expected_seq);
		sum_len   = {17'd0, base} + {1'b0, h_len};
		fits      = sum_len <= FRAME_CAP33;
		type_ok   = h_type == accepted_type;
		pos       = idx - HDR_BYTES16;
		total     = (idx == IDX_MAX) ? IDX_MAX : idx + 16'd1;

		res = '0;
		nst = st;
		nst.header_type     = h_type;
		nst.header_sequence = h_seq;
		nst.header_flags    = h_flags;
		nst.header_length   = h_len;

		// payload write, suppressed once the counter has saturated
		if (idx >= HDR_BYTES16 && idx != IDX_MAX && {16'd0, pos} < h_len
		    && type_ok && seq_ok && fits) begin
			res.payload_byte   = data_byte;
			res.payload_valid  = 1'b1;
			res.payload_target = !frag;
			res.write_offset   = base + pos;
		end

		if (!packet_end) begin
			nst.byte_index = total;
		end else begin
			res.packet_done = 1'b1;
			if (total < HDR_BYTES16) begin
				res.status = ST_SHORT;
			end else if ({17'd0, total} < HDR_BYTES33 + {1'b0, h_len}) begin
				res.status = ST_INCOMPLETE;
			end else if (!type_ok) begin
				res.status = ST_WRONG_TYPE;
			end else if (frag) begin
				if (!seq_ok) begin
					res.status          = ST_SEQ_MISM;
					res.dropped_partial = 1'b1;
					nst.reassembling     = 1'b0;
					nst.committed_length = 16'd0;
				end else if (!fits) begin
					res.status          = ST_OVERFLOW;
					res.dropped_partial = st.reassembling;
					nst.reassembling     = 1'b0;
					nst.committed_length = 16'd0;
				end else begin
					nst.expected_seq = h_seq + 32'd1;
					if (h_flags[FLAG_LAST_BIT]) begin
						res.status       = ST_COMPLETE;
						res.frame_ready  = 1'b1;
						res.frame_length = sum_len[15:0];
						nst.reassembling     = 1'b0;
						nst.committed_length = 16'd0;
					end else begin
						res.status           = ST_APPENDED;
						nst.reassembling     = 1'b1;
						nst.committed_length = sum_len[15:0];
					end
				end
			end else begin
				res.dropped_partial  = st.reassembling;
				nst.reassembling     = 1'b0;
				nst.committed_length = 16'd0;
				if (!fits) begin
					res.status = ST_OVERFLOW;
				end else begin
					res.status       = ST_SINGLE;
					res.frame_ready  = 1'b1;
					res.frame_length = h_len[15:0];
				end
			end
			// header fields start fresh for the next packet
			nst.byte_index      = 16'd0;
			nst.header_type     = 8'd0;
			nst.header_sequence = 32'd0;
			nst.header_flags    = 8'd0;
			nst.header_length   = 32'd0;
		end
	end

endmodule

FILE: rtl/packet_fragment_reassembler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_fragment_reassembler_top
// Byte-stream packet parser that places payload into a reassembly or frame
// buffer and reports a per-packet status on the last byte.
// ----------------------------------------------------------------------------
// Usage: feed packet bytes on s_axis, one per transfer, with tlast on the final
// byte. Every input transfer yields exactly one output transfer, in order.
// The block sustains one byte per clock while m_axis accepts its results: a
// byte is taken into the input register, and then the per-byte logic (two
// 33-bit adds and a few compares against the header length and the committed
// length) updates the parser state and loads the result register, which
// drives m_axis. Both stages advance together whenever the result register
// is empty or being taken, so backpressure on m_axis holds the stages
// without losing data. accepted_type is written through cfg_wr_en / cfg_wr_data
// and must only be changed while no packet bytes are in flight.
// The header is 18 bytes: type, big-endian sequence (bytes 1..4), flags
// (byte 13; bit 1 fragment, bit 2 last fragment) and big-endian payload
// length (bytes 14..17).
// ----------------------------------------------------------------------------
module packet_fragment_reassembler_top import pfr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,     // accepted_type
	// byte input
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,    // [7:0] data_byte
	input  logic        s_axis_tlast,    // packet_end
	// result output
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [7:0] payload_byte, [8] payload_valid, [24:9] write_offset,
	// [27:25] status, [28] frame_ready, [44:29] frame_length,
	// [45] dropped_partial, [47:46] zero
	output logic [47:0] m_axis_tdata,
	output logic        m_axis_tlast,    // packet_done
	output logic        m_axis_tuser     // payload_target
);

	logic [7:0]  accepted_type_q;

	// input register
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        end_s1;

	// result register
	logic        valid_s2;
	pfr_result_t res_s2;

	pfr_state_t  state_q;
	pfr_state_t  state_nxt;
	pfr_result_t res_nxt;

	logic        advance;
	logic        in_xfer;

	// s1 moves on when the result slot is free or being drained
	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;

	pfr_step u_step (
		.st            (state_q),
		.accepted_type (accepted_type_q),
		.data_byte     (byte_s1),
		.packet_end    (end_s1),
		.nst           (state_nxt),
		.res           (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accepted_type_q <= ACCEPTED_TYPE_RST;
		end else if (cfg_wr_en) begin
			accepted_type_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			byte_s1 <= s_axis_tdata;
			end_s1  <= s_axis_tlast;
		end
	end

	// parser state commits only when a byte is actually processed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tlast  = res_s2.packet_done;
	assign m_axis_tuser  = res_s2.payload_target;
	assign m_axis_tdata  = {2'b00, res_s2.dropped_partial, res_s2.frame_length,
	                        res_s2.frame_ready, res_s2.status, res_s2.write_offset,
	                        res_s2.payload_valid, res_s2.payload_byte};

	// a ready frame is only ever reported on a packet's last byte
	a_frame_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.frame_ready |->
			res_s2.packet_done && (res_s2.status == ST_SINGLE
			                       || res_s2.status == ST_COMPLETE))
		else $error("frame_ready outside a single or complete verdict");

	a_drop_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.dropped_partial |-> res_s2.packet_done)
		else $error("dropped_partial without packet end");

	// after a packet end is processed the parser restarts at header byte 0
	a_index_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		advance && end_s1 |=> state_q.byte_index == 16'd0
		                      && state_q.header_length == 32'd0)
		else $error("header state not cleared after packet end");

	a_commit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!state_q.reassembling |-> state_q.committed_length == 16'd0)
		else $error("committed length held while not reassembling");

endmodule
